/* rtl/xbm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XBM parser package
// Shared types, character codes, error codes and bit helpers.
// ----------------------------------------------------------------------------
package xbm_pkg;

   typedef enum logic [2:0] {
      PH_LINE   = 3'd0,
      PH_ZERO   = 3'd1,
      PH_X      = 3'd2,
      PH_DIGITS = 3'd3,
      PH_TRAIL  = 3'd4,
      PH_SEP    = 3'd5
   } phase_type;

   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_HEX     = 2'd1;
   localparam logic [1:0] ERR_ILLEGAL = 2'd2;
   localparam logic [1:0] ERR_END     = 2'd3;

   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_NL     = 8'h0a;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_COMMA  = 8'h2c;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_X      = 8'h78;
   localparam logic [7:0] CHAR_RBRACE = 8'h7d;

   localparam logic [15:0] WIDTH_RESET = 16'd8;

   typedef struct packed {
      logic       emit;
      logic [7:0] pixel_byte;
      logic       byte_valid;
      logic       row_end;
      logic [1:0] error_code;
   } result_type;

   // {valid, digit}
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   function automatic logic [7:0] mirror8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = v[7 - i];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* rtl/xbm_parser_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XBM parser core
// Token state machine, value accumulator, row counter and error latch.
// ----------------------------------------------------------------------------
module xbm_parser_core (
   input  wire               clock,
   input  wire               reset,
   input  wire               step_en,
   input  wire               kind,
   input  wire  [7:0]        char_code,
   input  wire  [15:0]       image_width,
   output xbm_pkg::result_type result
);

   xbm_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  acc_ff, acc_in;
   logic [12:0] row_ff, row_in;
   logic        err_ff, err_in;

   logic        blank, sep, eol, is_zero, is_x, is_nl;
   logic [4:0]  hex;
   logic [16:0] width_sum;
   logic [13:0] row_bytes;
   logic        last;
   logic        do_byte, do_err;
   logic [1:0]  err_code;

   assign blank   = (char_code == xbm_pkg::CHAR_SPACE) || (char_code == xbm_pkg::CHAR_TAB);
   assign sep     = (char_code == xbm_pkg::CHAR_COMMA) || (char_code == xbm_pkg::CHAR_RBRACE);
   assign eol     = (char_code == xbm_pkg::CHAR_NL) || (char_code == xbm_pkg::CHAR_NUL);
   assign is_nl   = (char_code == xbm_pkg::CHAR_NL);
   assign is_zero = (char_code == xbm_pkg::CHAR_ZERO);
   assign is_x    = (char_code == xbm_pkg::CHAR_X);
   assign hex     = xbm_pkg::hex_decode(char_code);

   assign width_sum = {1'b0, image_width} + 17'd7;
   assign row_bytes = (width_sum[16:3] == 14'd0) ? 14'd1 : width_sum[16:3];
   assign last      = ({1'b0, row_ff} + 14'd1) >= row_bytes;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (step_en && !err_ff) begin
         if (kind) begin
            case (phase_ff)
               xbm_pkg::PH_ZERO, xbm_pkg::PH_X, xbm_pkg::PH_SEP: phase_in = phase_ff;
               default: phase_in = xbm_pkg::PH_LINE;
            endcase
         end else begin
            case (phase_ff)
               xbm_pkg::PH_ZERO: begin
                  if (is_x) phase_in = xbm_pkg::PH_X;
               end
               xbm_pkg::PH_X: begin
                  if (hex[4]) phase_in = xbm_pkg::PH_DIGITS;
               end
               xbm_pkg::PH_DIGITS, xbm_pkg::PH_TRAIL: begin
                  if (phase_ff == xbm_pkg::PH_DIGITS && hex[4]) phase_in = xbm_pkg::PH_DIGITS;
                  else if (blank) phase_in = xbm_pkg::PH_TRAIL;
                  else if (eol)   phase_in = xbm_pkg::PH_LINE;
                  else if (sep)   phase_in = xbm_pkg::PH_SEP;
               end
               xbm_pkg::PH_SEP: begin
                  if (blank)        phase_in = xbm_pkg::PH_SEP;
                  else if (is_nl)   phase_in = xbm_pkg::PH_LINE;
                  else if (is_zero) phase_in = xbm_pkg::PH_ZERO;
               end
               default: begin
                  if (blank)        phase_in = xbm_pkg::PH_LINE;
                  else if (is_zero) phase_in = xbm_pkg::PH_ZERO;
               end
            endcase
         end
      end
   end

   // outputs and datapath updates
   always_comb begin
      do_byte  = 1'b0;
      do_err   = 1'b0;
      err_code = xbm_pkg::ERR_NONE;
      acc_in   = acc_ff;
      if (kind) begin
         case (phase_ff)
            xbm_pkg::PH_ZERO, xbm_pkg::PH_X: begin
               do_err   = 1'b1;
               err_code = xbm_pkg::ERR_HEX;
            end
            xbm_pkg::PH_DIGITS, xbm_pkg::PH_TRAIL: do_byte = 1'b1;
            xbm_pkg::PH_SEP: begin
               do_err   = (row_ff != 13'd0);
               err_code = xbm_pkg::ERR_HEX;
            end
            default: begin
               do_err   = (row_ff != 13'd0);
               err_code = xbm_pkg::ERR_END;
            end
         endcase
      end else begin
         case (phase_ff)
            xbm_pkg::PH_ZERO: begin
               do_err   = !is_x;
               err_code = xbm_pkg::ERR_HEX;
            end
            xbm_pkg::PH_X: begin
               do_err   = !hex[4];
               err_code = xbm_pkg::ERR_HEX;
               acc_in   = {4'd0, hex[3:0]};
            end
            xbm_pkg::PH_DIGITS, xbm_pkg::PH_TRAIL: begin
               if (phase_ff == xbm_pkg::PH_DIGITS && hex[4]) begin
                  acc_in = {acc_ff[3:0], hex[3:0]};
               end else if (!blank) begin
                  do_byte  = eol || sep;
                  do_err   = !(eol || sep);
                  err_code = xbm_pkg::ERR_ILLEGAL;
               end
            end
            xbm_pkg::PH_SEP: begin
               do_err   = !(blank || is_nl || is_zero);
               err_code = xbm_pkg::ERR_HEX;
               if (is_zero) acc_in = 8'd0;
            end
            default: begin
               do_err   = !(blank || is_zero);
               err_code = xbm_pkg::ERR_HEX;
               if (is_zero) acc_in = 8'd0;
            end
         endcase
      end
      if (do_byte) acc_in = 8'd0;

      row_in = row_ff;
      err_in = err_ff;
      if (step_en && !err_ff) begin
         if (do_byte) row_in = last ? 13'd0 : (row_ff + 13'd1);
         if (do_err)  err_in = 1'b1;
      end else begin
         acc_in = acc_ff;
      end

      result.emit       = step_en && !err_ff && (do_byte || do_err);
      result.pixel_byte = do_byte ? ~xbm_pkg::mirror8(acc_ff) : 8'd0;
      result.byte_valid = do_byte;
      result.row_end    = do_byte && last;
      result.error_code = do_byte ? xbm_pkg::ERR_NONE : err_code;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= xbm_pkg::PH_LINE;
         acc_ff   <= 8'd0;
         row_ff   <= 13'd0;
         err_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         row_ff   <= row_in;
         err_ff   <= err_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/xbm_hex_data_parser.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XBM hex data parser
// Turns the hex pixel text of an XBM image into inverted, mirrored bytes.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one text character per item (tuser high marks end of
//   input). rsp_* carries a pixel byte with tlast on the last byte of a
//   row, or a single error item; after an error no further item appears
//   until reset. csr_wr_en/csr_wr_data set the image width in pixels while
//   the block is idle.
// Timing:
//   An item is held in an input register, then parsed combinationally into
//   the result register, from which its result is offered. One item per
//   cycle is sustained while no result is held back by rsp_tready low; the
//   token state machine updates once per character.
// Reset:
//   Width returns to 8, parsing restarts at line start, the error latch
//   and row counter clear, both register stages empty.
// Stall:
//   With a result pending and rsp_tready low the result register holds; the
//   input register takes one more item if empty, then req_tready drops.
// ----------------------------------------------------------------------------
module xbm_hex_data_parser (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] char_code
   input  wire         req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] pixel_byte
   output logic [2:0]  rsp_tuser,   // [0] byte_valid, [2:1] error_code
   output logic        rsp_tlast,   // row_end
   input  wire         csr_wr_en,
   input  wire  [15:0] csr_wr_data
);

   logic [15:0] width_ff;
   logic        in_valid_ff;
   logic        in_kind_ff;
   logic [7:0]  in_char_ff;
   logic        out_valid_ff;
   logic [7:0]  out_pixel_ff;
   logic        out_bvalid_ff;
   logic        out_last_ff;
   logic [1:0]  out_err_ff;
   logic        advance;
   xbm_pkg::result_type result;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   xbm_parser_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step_en     (advance),
      .kind        (in_kind_ff),
      .char_code   (in_char_ff),
      .image_width (width_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= xbm_pkg::WIDTH_RESET;
      end else if (csr_wr_en) begin
         width_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_kind_ff <= req_tuser;
         in_char_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && result.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.emit) begin
         out_pixel_ff  <= result.pixel_byte;
         out_bvalid_ff <= result.byte_valid;
         out_last_ff   <= result.row_end;
         out_err_ff    <= result.error_code;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_pixel_ff;
   assign rsp_tuser  = {out_err_ff, out_bvalid_ff};
   assign rsp_tlast  = out_last_ff;

   a_byte_xor_error: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[0] != (rsp_tuser[2:1] != xbm_pkg::ERR_NONE)))
      else $error("result must be either a byte or an error");

   a_error_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && (rsp_tuser[2:1] != xbm_pkg::ERR_NONE)) |=> !rsp_tvalid)
      else $error("item delivered after an error");

   a_last_is_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tuser[0])
      else $error("row end on a non-byte item");

endmodule
`default_nettype wire

/* sim/xbm_hex_data_parser_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XBM hex data parser testbench
// Feeds the parser the hex text of XBM pixel data, one character per item:
// a short directed run, then well-formed token streams with random digits,
// blanks, terminators and end-of-input markers over a range of image widths,
// ending with one broken sequence and trailing noise. A predictor tracks the
// token state, row position and error latch, and every result item is
// checked field by field in order. Both sides idle at random but in one calm
// pass; once the receiver holds off long enough for the parser to stall input.
// ----------------------------------------------------------------------------
module xbm_hex_data_parser_tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam int STALL_CYCLES = 150;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;

   typedef struct packed {
      logic       kind;
      logic [7:0] code;
   } char_item_type;

   typedef struct packed {
      logic [7:0] pixel;
      logic       valid;
      logic       last;
      logic [1:0] code;
   } pixel_result_type;

   typedef enum {TERM_COMMA, TERM_BRACE, TERM_NL, TERM_NUL, TERM_END, TERM_ANY} term_type;
   typedef enum {BREAK_X, BREAK_HEX, BREAK_DIGIT_END, BREAK_LINE, BREAK_SEP} break_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'h0000;

   char_item_type    char_queue[$];
   pixel_result_type parsed_bytes[$];

   // parser shadow state
   logic [15:0]        model_width;
   xbm_pkg::phase_type model_phase;
   logic [7:0]         model_acc;
   logic [12:0]        row_index;
   bit                 err_seen;

   // stream generator bookkeeping
   int gen_idx;
   int gen_rb;
   bit gen_in_sep;
   int gen_count;

   bit item_taken = 1'b0;
   bit calm = 1'b0;
   int stall_ask = 0;
   int stall_done = 0;
   int stall_left = 0;
   int mismatches = 0;
   int cycle_count = 0;
   char_item_type next_item;
   pixel_result_type got, want;

   xbm_hex_data_parser dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),   // [7:0] char_code
      .req_tuser   (req_tuser),   // [0] kind
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),   // [7:0] pixel_byte
      .rsp_tuser   (rsp_tuser),   // [0] byte_valid, [2:1] error_code
      .rsp_tlast   (rsp_tlast),   // row_end
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int bytes_per_row(input logic [15:0] w);
      int n;
      n = (int'(w) + 7) >> 3;
      return (n == 0) ? 1 : n;
   endfunction

   // {valid, digit}
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= xbm_pkg::CHAR_ZERO && c <= xbm_pkg::CHAR_ZERO + 8'd9) begin
         r = {1'b1, c[3:0]};
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_A + 8'd5) begin
         r = {1'b1, 4'(c - CHAR_LOWER_A + 8'd10)};
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_A + 8'd5) begin
         r = {1'b1, 4'(c - CHAR_UPPER_A + 8'd10)};
      end
      return r;
   endfunction

   function automatic bit is_blank(input logic [7:0] c);
      return c == xbm_pkg::CHAR_SPACE || c == xbm_pkg::CHAR_TAB;
   endfunction

   task automatic flag_error(input logic [1:0] code);
      err_seen = 1'b1;
      parsed_bytes.push_back('{pixel: 8'h00, valid: 1'b0, last: 1'b0, code: code});
   endtask

   task automatic emit_pixel();
      logic [7:0] v;
      logic [7:0] r;
      bit         last;
      v = model_acc;
      r = 8'h00;
      for (int i = 0; i < 8; i++) begin
         r = {r[6:0], v[0]};
         v = v >> 1;
      end
      last = (int'(row_index) + 1 >= bytes_per_row(model_width));
      parsed_bytes.push_back('{pixel: ~r, valid: 1'b1, last: last, code: xbm_pkg::ERR_NONE});
      row_index = last ? 13'd0 : row_index + 13'd1;
      model_acc = 8'h00;
   endtask

   task automatic parse_char(input logic kind, input logic [7:0] c);
      logic [4:0] hd;
      bit         blank, sep, eol;
      hd = hex_digit(c);
      blank = is_blank(c);
      sep = (c == xbm_pkg::CHAR_COMMA || c == xbm_pkg::CHAR_RBRACE);
      eol = (c == xbm_pkg::CHAR_NL || c == xbm_pkg::CHAR_NUL);
      if (err_seen) begin
      end else if (kind) begin
         case (model_phase)
            xbm_pkg::PH_ZERO, xbm_pkg::PH_X: flag_error(xbm_pkg::ERR_HEX);
            xbm_pkg::PH_DIGITS, xbm_pkg::PH_TRAIL: begin
               model_phase = xbm_pkg::PH_LINE;
               emit_pixel();
            end
            xbm_pkg::PH_SEP: if (row_index != 13'd0) flag_error(xbm_pkg::ERR_HEX);
            default: begin
               if (row_index != 13'd0) flag_error(xbm_pkg::ERR_END);
               else model_phase = xbm_pkg::PH_LINE;
            end
         endcase
      end else begin
         case (model_phase)
            xbm_pkg::PH_ZERO: begin
               if (c != xbm_pkg::CHAR_X) flag_error(xbm_pkg::ERR_HEX);
               else model_phase = xbm_pkg::PH_X;
            end
            xbm_pkg::PH_X: begin
               if (!hd[4]) begin
                  flag_error(xbm_pkg::ERR_HEX);
               end else begin
                  model_acc = {4'd0, hd[3:0]};
                  model_phase = xbm_pkg::PH_DIGITS;
               end
            end
            xbm_pkg::PH_DIGITS, xbm_pkg::PH_TRAIL: begin
               if (model_phase == xbm_pkg::PH_DIGITS && hd[4]) begin
                  model_acc = {model_acc[3:0], hd[3:0]};
               end else if (blank) begin
                  model_phase = xbm_pkg::PH_TRAIL;
               end else if (eol) begin
                  model_phase = xbm_pkg::PH_LINE;
                  emit_pixel();
               end else if (sep) begin
                  model_phase = xbm_pkg::PH_SEP;
                  emit_pixel();
               end else begin
                  flag_error(xbm_pkg::ERR_ILLEGAL);
               end
            end
            xbm_pkg::PH_SEP: begin
               if (blank) begin
               end else if (c == xbm_pkg::CHAR_NL) begin
                  model_phase = xbm_pkg::PH_LINE;
               end else if (c == xbm_pkg::CHAR_ZERO) begin
                  model_acc = 8'h00;
                  model_phase = xbm_pkg::PH_ZERO;
               end else begin
                  flag_error(xbm_pkg::ERR_HEX);
               end
            end
            default: begin
               if (blank) begin
                  model_phase = xbm_pkg::PH_LINE;
               end else if (c == xbm_pkg::CHAR_ZERO) begin
                  model_acc = 8'h00;
                  model_phase = xbm_pkg::PH_ZERO;
               end else begin
                  flag_error(xbm_pkg::ERR_HEX);
               end
            end
         endcase
      end
   endtask

   // check results first, then predict for the item taken at this edge
   always @(posedge clock) begin
      if (reset) begin
         model_width = xbm_pkg::WIDTH_RESET;
         model_phase = xbm_pkg::PH_LINE;
         model_acc = 8'h00;
         row_index = 13'd0;
         err_seen = 1'b0;
         item_taken = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{pixel: rsp_tdata, valid: rsp_tuser[0], last: rsp_tlast,
                    code: rsp_tuser[2:1]};
            if (parsed_bytes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: byte %02h valid %0d last %0d code %0d",
                           got.pixel, got.valid, got.last, got.code);
            end else begin
               want = parsed_bytes.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: expected byte %02h valid %0d last %0d code %0d,",
                               " got byte %02h valid %0d last %0d code %0d"},
                              want.pixel, want.valid, want.last, want.code,
                              got.pixel, got.valid, got.last, got.code);
               end
            end
         end
         if (csr_wr_en) model_width = csr_wr_data;
         item_taken = req_tvalid && req_tready;
         if (item_taken) parse_char(req_tuser, req_tdata);
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (item_taken || !req_tvalid) begin
         if (char_queue.size() > 0 && (calm || $urandom_range(99) >= 27)) begin
            next_item = char_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= next_item.code;
            req_tuser <= next_item.kind;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (stall_done != stall_ask) begin
         stall_left = STALL_CYCLES;
         stall_done = stall_ask;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 27);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("xbm_hex_data_parser_tb: errors");
         $finish;
      end
   end

   task automatic push_item(input bit kind, input logic [7:0] code);
      char_queue.push_back('{kind: kind, code: code});
      gen_count++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_item(1'b0, s[i]);
   endtask

   task automatic push_blanks(input int maxn);
      repeat ($urandom_range(maxn, 0))
         push_item(1'b0, $urandom_range(1) ? xbm_pkg::CHAR_SPACE : xbm_pkg::CHAR_TAB);
   endtask

   function automatic logic [7:0] rand_hex_char();
      int d;
      d = $urandom_range(15);
      if (d < 10) return xbm_pkg::CHAR_ZERO + 8'(d);
      if ($urandom_range(1)) return CHAR_LOWER_A + 8'(d - 10);
      return CHAR_UPPER_A + 8'(d - 10);
   endfunction

   function automatic bit harmless(input break_type cls, input logic [7:0] c);
      case (cls)
         BREAK_X:         return c == xbm_pkg::CHAR_X;
         BREAK_HEX:       return hex_digit(c) >= 5'h10;
         BREAK_DIGIT_END: return hex_digit(c) >= 5'h10 || is_blank(c) ||
                                 c == xbm_pkg::CHAR_COMMA || c == xbm_pkg::CHAR_RBRACE ||
                                 c == xbm_pkg::CHAR_NL || c == xbm_pkg::CHAR_NUL;
         BREAK_LINE:      return is_blank(c) || c == xbm_pkg::CHAR_ZERO;
         default:         return is_blank(c) || c == xbm_pkg::CHAR_NL ||
                                 c == xbm_pkg::CHAR_ZERO;
      endcase
   endfunction

   function automatic logic [7:0] pick_breaking(input break_type cls);
      logic [7:0] c;
      c = 8'($urandom_range(255));
      while (harmless(cls, c)) c = 8'($urandom_range(255));
      return c;
   endfunction

   task automatic count_byte();
      if (gen_idx + 1 >= gen_rb) gen_idx = 0;
      else gen_idx++;
   endtask

   task automatic push_token(input term_type term);
      int       nd;
      int       r;
      term_type t;
      push_item(1'b0, xbm_pkg::CHAR_ZERO);
      push_item(1'b0, xbm_pkg::CHAR_X);
      nd = ($urandom_range(9) == 0) ? $urandom_range(6, 3) : $urandom_range(2, 1);
      repeat (nd) push_item(1'b0, rand_hex_char());
      if ($urandom_range(3) == 0) push_blanks(2);
      t = term;
      if (t == TERM_ANY) begin
         r = $urandom_range(9);
         t = (r < 4) ? TERM_COMMA : (r == 4) ? TERM_BRACE : (r < 7) ? TERM_NL :
             (r == 7) ? TERM_NUL : TERM_END;
      end
      case (t)
         TERM_COMMA: push_item(1'b0, xbm_pkg::CHAR_COMMA);
         TERM_BRACE: push_item(1'b0, xbm_pkg::CHAR_RBRACE);
         TERM_NL:    push_item(1'b0, xbm_pkg::CHAR_NL);
         TERM_NUL:   push_item(1'b0, xbm_pkg::CHAR_NUL);
         default:    push_item(1'b1, 8'($urandom_range(255)));
      endcase
      gen_in_sep = (t == TERM_COMMA || t == TERM_BRACE);
      count_byte();
   endtask

   task automatic push_gap();
      if (gen_in_sep) begin
         push_blanks(2);
         if ($urandom_range(3) == 0) begin
            push_item(1'b0, xbm_pkg::CHAR_NL);
            gen_in_sep = 1'b0;
         end
      end
      if (!gen_in_sep) push_blanks(2);
      if (gen_idx == 0 && $urandom_range(5) == 0) push_item(1'b1, 8'($urandom_range(255)));
   endtask

   task automatic push_stream(input int n);
      int target;
      target = gen_count + n;
      while (gen_count < target) begin
         push_gap();
         push_token(TERM_ANY);
      end
   endtask

   task automatic push_broken();
      case ($urandom_range(8))
         0: begin
            push_gap();
            push_item(1'b0, xbm_pkg::CHAR_ZERO);
            push_item(1'b0, pick_breaking(BREAK_X));
         end
         1: begin
            push_gap();
            push_item(1'b0, xbm_pkg::CHAR_ZERO);
            push_item(1'b0, xbm_pkg::CHAR_X);
            push_item(1'b0, pick_breaking(BREAK_HEX));
         end
         2: begin
            push_gap();
            push_item(1'b0, xbm_pkg::CHAR_ZERO);
            push_item(1'b0, xbm_pkg::CHAR_X);
            push_item(1'b0, rand_hex_char());
            push_item(1'b0, pick_breaking(BREAK_DIGIT_END));
         end
         3: begin
            push_gap();
            push_item(1'b0, xbm_pkg::CHAR_ZERO);
            push_item(1'b0, xbm_pkg::CHAR_X);
            push_item(1'b0, rand_hex_char());
            push_item(1'b0, xbm_pkg::CHAR_SPACE);
            push_item(1'b0, rand_hex_char());
         end
         4: begin
            if (gen_in_sep) push_item(1'b0, xbm_pkg::CHAR_NL);
            gen_in_sep = 1'b0;
            push_item(1'b0, pick_breaking(BREAK_LINE));
         end
         5: begin
            push_gap();
            push_token(TERM_COMMA);
            push_item(1'b0, pick_breaking(BREAK_SEP));
         end
         6: begin
            push_gap();
            push_item(1'b0, xbm_pkg::CHAR_ZERO);
            if ($urandom_range(1)) push_item(1'b0, xbm_pkg::CHAR_X);
            push_item(1'b1, 8'($urandom_range(255)));
         end
         7: begin
            if (gen_idx == 0) begin
               push_gap();
               push_token(TERM_NL);
            end
            if (gen_in_sep) push_item(1'b0, xbm_pkg::CHAR_NL);
            gen_in_sep = 1'b0;
            push_item(1'b1, 8'($urandom_range(255)));
         end
         default: begin
            push_gap();
            push_token(TERM_COMMA);
            if (gen_idx == 0) push_token(TERM_COMMA);
            push_item(1'b1, 8'($urandom_range(255)));
         end
      endcase
   endtask

   task automatic drain();
      bit quiet;
      quiet = 1'b0;
      while (!quiet) begin
         @(posedge clock);
         quiet = (char_queue.size() == 0) && !req_tvalid;
         @(negedge clock);
         quiet = quiet && (parsed_bytes.size() == 0);
      end
      repeat (6) @(posedge clock);
   endtask

   task automatic write_width(input logic [15:0] w);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= w;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      gen_rb = bytes_per_row(w);
   endtask

   initial begin : stimulus
      int          p;
      logic [15:0] w;
      int          widths[6];
      widths = '{1, 65535, 8, 0, 9, 64};
      gen_idx = 0;
      gen_rb = bytes_per_row(xbm_pkg::WIDTH_RESET);
      gen_in_sep = 1'b0;
      gen_count = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      push_text("0x00,");
      push_text("\t0xA5 }");
      push_text(" \n0x1b2F");
      push_item(1'b0, xbm_pkg::CHAR_NUL);
      push_item(1'b1, 8'hff);
      push_text("0xff");
      push_item(1'b1, 8'h00);
      drain();

      for (p = 0; p < 8; p++) begin
         if (p < 6) w = 16'(widths[p]);
         else if ($urandom_range(1)) w = 16'($urandom_range(40, 1));
         else w = 16'($urandom_range(65535, 1));
         write_width(w);
         calm = (p == 2);
         push_stream(100);
         if (p == 3) stall_ask++;
         drain();
      end
      calm = 1'b0;

      write_width(16'd40);
      push_stream(30);
      push_broken();
      repeat (40) push_item(1'($urandom_range(1)), 8'($urandom_range(255)));
      drain();
      repeat (10) @(posedge clock);

      if (mismatches == 0 && parsed_bytes.size() == 0) begin
         $display("xbm_hex_data_parser_tb: clean");
      end else begin
         $display("xbm_hex_data_parser_tb: errors");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/xbm_pkg.sv
rtl/xbm_parser_core.sv
rtl/xbm_hex_data_parser.sv
sim/xbm_hex_data_parser_tb.sv
